// ===== rtl/hng_pkg.sv =====
// Shared types and constants of the height-map normal generator.
package hng_pkg;

  localparam int HNG_MAX_WIDTH = 1024;
  localparam int HNG_Q_DEPTH   = 2;
  localparam int HNG_Q_AW      = $clog2(HNG_Q_DEPTH);

  localparam logic [10:0] HNG_WIDTH_RST = 11'd256;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [7:0] sample;
  } hng_in_t;

  typedef struct packed {
    logic [9:0]         grid_x;
    logic [9:0]         grid_z;
    logic [7:0]         height;
    logic signed [15:0] normal_x;
    logic [14:0]        normal_y;
    logic signed [15:0] normal_z;
    logic               last;
  } hng_out_t;

  typedef struct packed {
    logic [9:0]        grid_x;
    logic [9:0]        grid_z;
    logic [7:0]        height;
    logic signed [8:0] diff_x;
    logic signed [8:0] diff_z;
    logic              last;
  } hng_job_t;

  typedef enum logic [2:0] {
    FE_IDLE,
    FE_RD_C,
    FE_RD_N,
    FE_CAP,
    FE_PUSH
  } fe_state_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SUM,
    BK_LOAD,
    BK_DIV,
    BK_SQRT,
    BK_NEXT,
    BK_DONE
  } bk_state_t;

endpackage

// ===== rtl/heightmap_normal_generator.sv =====
// Top level of the height-map normal generator: config register and block wiring.
// Pixels of a square height map enter in raster order; each pixel of row z>0
// releases vertex (x,z-1), and once the last pixel is in, flush requests
// release the last row one vertex each (pixels are dropped while a flush is
// pending, flushes are dropped otherwise). The front end walks its read,
// capture and push states per request (line-store reads and write-back, one
// port per store) and takes no new request until back in idle; the normal
// engine runs three components each through a 32-step restoring divider and
// a 16-step square root, so it paces a vertex-producing stream. A two-entry
// queue separates the two, and an output register holds a finished vertex
// while the next is computed. The user must write grid_width (byte address 0)
// only while idle (not enforced by the block); it is clamped to 2..MAX_WIDTH.
module heightmap_normal_generator #(
  parameter int MAX_WIDTH = hng_pkg::HNG_MAX_WIDTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  hng_pkg::hng_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output hng_pkg::hng_out_t out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [1:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import hng_pkg::*;

  logic [10:0] grid_width_r;
  logic        cfg_wr;
  logic        fq_valid, fq_ready, qb_valid, qb_ready;
  hng_job_t    fq_data, qb_data;

  assign cfg_wr = psel && penable && pwrite && (paddr[1:0] == 2'd0);
  assign pready = 1'b1;
  assign prdata = 32'(grid_width_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r <= HNG_WIDTH_RST;
    end else if (cfg_wr) begin
      grid_width_r <= pwdata[10:0];
    end
  end

  hng_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .grid_width (grid_width_r),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .job_valid  (fq_valid),
    .job_ready  (fq_ready),
    .job_data   (fq_data)
  );

  hng_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_data),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_data   (qb_data)
  );

  hng_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (qb_valid),
    .job_ready (qb_ready),
    .job_data  (qb_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/hng_front.sv =====
// Front end: request intake, raster counters, line stores and job building.
module hng_front #(
  parameter int MAX_WIDTH = hng_pkg::HNG_MAX_WIDTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [10:0]       grid_width,
  input  logic              in_valid,
  output logic              in_ready,
  input  hng_pkg::hng_in_t  in_data,
  output logic              job_valid,
  input  logic              job_ready,
  output hng_pkg::hng_job_t job_data
);
  import hng_pkg::*;

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = AW + 1;

  fe_state_t state_r, state_nxt;

  logic [AW-1:0] col_r, col_nxt;
  logic [WW-1:0] row_r, row_nxt;
  logic [AW-1:0] fcnt_r, fcnt_nxt;
  logic          pend_r, pend_nxt;

  logic [WW-1:0] w;
  logic          take;
  logic          is_flush;
  logic [AW-1:0] x_sel;
  logic [WW-1:0] col_inc, fcnt_inc, x_inc;

  logic [AW-1:0] x_r;
  logic [9:0]    z_r;
  logic          flush_r, l_ok_r, r_ok_r, d_ok_r, emit_r, last_r;
  logic [7:0]    u_r, cen_r, dm_r, l_r, r_r;

  logic [7:0]    older_mem_r [MAX_WIDTH];
  logic [7:0]    newer_mem_r [MAX_WIDTH];
  logic [7:0]    older_q_r, newer_q_r;
  logic [AW-1:0] raddr_o, raddr_n;
  logic          mem_we;

  logic [7:0]    lv, rv, dv, uv;

  always_comb begin
    if (grid_width < 11'd2) begin
      w = WW'(2);
    end else if (32'(grid_width) > MAX_WIDTH) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = WW'(grid_width);
    end
  end

  assign is_flush = (in_data.req_type == REQ_FLUSH);
  assign take     = in_valid && in_ready && (is_flush ? pend_r : !pend_r);
  assign col_inc  = WW'(col_r) + WW'(1);
  assign fcnt_inc = WW'(fcnt_r) + WW'(1);
  assign x_sel    = is_flush ? fcnt_r : col_r;
  assign x_inc    = is_flush ? fcnt_inc : col_inc;

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    fcnt_nxt = fcnt_r;
    pend_nxt = pend_r;
    if (take && !is_flush) begin
      if (col_inc >= w) begin
        col_nxt = '0;
        row_nxt = row_r + WW'(1);
        if (row_r + WW'(1) >= w) begin
          pend_nxt = 1'b1;
          fcnt_nxt = '0;
        end
      end else begin
        col_nxt = col_inc[AW-1:0];
      end
    end else if (take) begin
      if (fcnt_inc >= w) begin
        pend_nxt = 1'b0;
        fcnt_nxt = '0;
        row_nxt  = '0;
        col_nxt  = '0;
      end else begin
        fcnt_nxt = fcnt_inc[AW-1:0];
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FE_IDLE: if (take) state_nxt = FE_RD_C;
      FE_RD_C: state_nxt = FE_RD_N;
      FE_RD_N: state_nxt = FE_CAP;
      FE_CAP:  state_nxt = FE_PUSH;
      FE_PUSH: if (!emit_r || job_ready) state_nxt = FE_IDLE;
      default: state_nxt = FE_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    job_valid = 1'b0;
    mem_we    = 1'b0;
    raddr_o   = l_ok_r ? x_r - AW'(1) : x_r;
    raddr_n   = r_ok_r ? x_r + AW'(1) : x_r;
    case (state_r)
      FE_IDLE: in_ready = 1'b1;
      FE_RD_C: begin
        raddr_o = x_r;
        raddr_n = x_r;
      end
      FE_PUSH: begin
        job_valid = emit_r;
        mem_we    = !emit_r || job_ready;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FE_IDLE;
      col_r   <= '0;
      row_r   <= '0;
      fcnt_r  <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      fcnt_r  <= fcnt_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      x_r     <= x_sel;
      flush_r <= is_flush;
      u_r     <= in_data.sample;
      l_ok_r  <= (x_sel != '0);
      r_ok_r  <= (x_inc < w);
      d_ok_r  <= is_flush || (row_r >= WW'(2));
      emit_r  <= is_flush || (row_r != '0);
      z_r     <= is_flush ? 10'(w - WW'(1)) : 10'(row_r - WW'(1));
      last_r  <= is_flush && (x_inc >= w);
    end
    if (state_r == FE_RD_N) begin
      cen_r <= newer_q_r;
      dm_r  <= older_q_r;
    end
    if (state_r == FE_CAP) begin
      l_r <= older_q_r;
      r_r <= newer_q_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      older_mem_r[x_r] <= cen_r;
      newer_mem_r[x_r] <= flush_r ? 8'd0 : u_r;
    end
    older_q_r <= older_mem_r[raddr_o];
    newer_q_r <= newer_mem_r[raddr_n];
  end

  assign lv = l_ok_r ? l_r : 8'd0;
  assign rv = r_ok_r ? r_r : 8'd0;
  assign dv = d_ok_r ? dm_r : 8'd0;
  assign uv = flush_r ? 8'd0 : u_r;

  always_comb begin
    job_data.grid_x = 10'(x_r);
    job_data.grid_z = z_r;
    job_data.height = cen_r;
    job_data.diff_x = $signed({1'b0, lv}) - $signed({1'b0, rv});
    job_data.diff_z = $signed({1'b0, dv}) - $signed({1'b0, uv});
    job_data.last   = last_r;
  end

`ifndef SYNTHESIS
  a_pend_col: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> col_r == '0)
    else $error("column counter not cleared while flush pending");
  a_push_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == FE_PUSH && emit_r && !job_ready) |=> state_r == FE_PUSH)
    else $error("front left push state without handing over job");
`endif

endmodule

// ===== rtl/hng_queue.sv =====
// Short job queue between the front end and the normal engine.
module hng_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  hng_pkg::hng_job_t push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output hng_pkg::hng_job_t pop_data
);
  import hng_pkg::*;

  hng_job_t              ent_r [HNG_Q_DEPTH];
  logic [HNG_Q_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [HNG_Q_AW:0]     cnt_r;
  logic                  do_push, do_pop;

  assign push_ready = (cnt_r != (HNG_Q_AW+1)'(HNG_Q_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = ent_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + HNG_Q_AW'(1);
      if (do_pop) rd_ptr_r <= rd_ptr_r + HNG_Q_AW'(1);
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + (HNG_Q_AW+1)'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - (HNG_Q_AW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) ent_r[wr_ptr_r] <= push_data;
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (HNG_Q_AW+1)'(HNG_Q_DEPTH))
    else $error("queue count overflow");
`endif

endmodule

// ===== rtl/hng_back.sv =====
// Normal engine: exact rounded unit normal by serial divide and square root.
module hng_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              job_valid,
  output logic              job_ready,
  input  hng_pkg::hng_job_t job_data,
  output logic              out_valid,
  input  logic              out_ready,
  output hng_pkg::hng_out_t out_data
);
  import hng_pkg::*;

  localparam logic [1:0]  COMP_X = 2'd0;
  localparam logic [1:0]  COMP_Y = 2'd1;
  localparam logic [1:0]  COMP_Z = 2'd2;
  localparam logic [8:0]  UP_MAG = 9'd510;
  localparam logic [18:0] UP_SQ  = 19'd260100;

  bk_state_t state_r, state_nxt;

  hng_job_t           job_r;
  logic [18:0]        s_r, rem_r;
  logic [1:0]         comp_r;
  logic [31:0]        k_r;
  logic [4:0]         cnt_r;
  logic [17:0]        sqr_r;
  logic [15:0]        root_r;
  logic signed [15:0] nx_r, nz_r;
  logic [14:0]        ny_r;
  logic               out_valid_r;
  hng_out_t           out_data_r;

  logic [8:0]  mag_x, mag_z, mag;
  logic        neg;
  logic [19:0] rem2;
  logic        div_ge;
  logic [19:0] sq_t, sq_trial;
  logic        sq_ge;
  logic [16:0] q17;
  logic [15:0] q;
  logic        load_out;

  assign mag_x = job_r.diff_x[8] ? 9'(-job_r.diff_x) : 9'(job_r.diff_x);
  assign mag_z = job_r.diff_z[8] ? 9'(-job_r.diff_z) : 9'(job_r.diff_z);

  always_comb begin
    case (comp_r)
      COMP_X: begin
        mag = mag_x;
        neg = job_r.diff_x[8];
      end
      COMP_Z: begin
        mag = mag_z;
        neg = job_r.diff_z[8];
      end
      default: begin
        mag = UP_MAG;
        neg = 1'b0;
      end
    endcase
  end

  assign rem2     = {rem_r, 1'b0};
  assign div_ge   = rem2 >= {1'b0, s_r};
  assign sq_t     = {sqr_r, k_r[31:30]};
  assign sq_trial = {2'b00, root_r, 2'b01};
  assign sq_ge    = sq_t >= sq_trial;
  assign q17      = {1'b0, root_r} + 17'd1;
  assign q        = q17[16:1];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: if (job_valid) state_nxt = BK_SUM;
      BK_SUM:  state_nxt = BK_LOAD;
      BK_LOAD: state_nxt = BK_DIV;
      BK_DIV:  if (cnt_r == 5'd31) state_nxt = BK_SQRT;
      BK_SQRT: if (cnt_r == 5'd15) state_nxt = BK_NEXT;
      BK_NEXT: state_nxt = (comp_r == COMP_Z) ? BK_DONE : BK_LOAD;
      BK_DONE: if (!out_valid_r || out_ready) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    job_ready = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      BK_IDLE: job_ready = 1'b1;
      BK_DONE: load_out  = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      BK_IDLE: begin
        job_r  <= job_data;
        comp_r <= COMP_X;
      end
      BK_SUM: begin
        s_r <= 19'(mag_x) * 19'(mag_x) + 19'(mag_z) * 19'(mag_z) + UP_SQ;
      end
      BK_LOAD: begin
        rem_r <= 19'(mag) * 19'(mag);
        cnt_r <= '0;
      end
      BK_DIV: begin
        rem_r <= div_ge ? 19'(rem2 - {1'b0, s_r}) : 19'(rem2);
        k_r   <= {k_r[30:0], div_ge};
        if (cnt_r == 5'd31) begin
          cnt_r  <= '0;
          sqr_r  <= '0;
          root_r <= '0;
        end else begin
          cnt_r <= cnt_r + 5'd1;
        end
      end
      BK_SQRT: begin
        sqr_r  <= sq_ge ? 18'(sq_t - sq_trial) : 18'(sq_t);
        root_r <= {root_r[14:0], sq_ge};
        k_r    <= {k_r[29:0], 2'b00};
        cnt_r  <= cnt_r + 5'd1;
      end
      BK_NEXT: begin
        case (comp_r)
          COMP_X:  nx_r <= neg ? -$signed(q) : $signed(q);
          COMP_Y:  ny_r <= q[15] ? 15'h7FFF : q[14:0];
          default: nz_r <= neg ? -$signed(q) : $signed(q);
        endcase
        comp_r <= comp_r + 2'd1;
      end
      BK_DONE: begin
        if (load_out) begin
          out_data_r.grid_x   <= job_r.grid_x;
          out_data_r.grid_z   <= job_r.grid_z;
          out_data_r.height   <= job_r.height;
          out_data_r.normal_x <= nx_r;
          out_data_r.normal_y <= ny_r;
          out_data_r.normal_z <= nz_r;
          out_data_r.last     <= job_r.last;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> out_valid_r)
    else $error("result load did not raise valid");
  a_ny_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r.normal_y != '0)
    else $error("normal y component is zero");
`endif

endmodule

// ===== test/testbench.sv =====
// Height-map normal generator testbench: directed and random streams vs. a vertex predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import hng_pkg::*;

  localparam int WDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES = 1500;
  localparam int SETTLE_CYCLES = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  hng_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  hng_out_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  heightmap_normal_generator u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  logic [7:0] line_old [HNG_MAX_WIDTH];
  logic [7:0] line_new [HNG_MAX_WIDTH];
  int unsigned col_pos, row_pos, flush_pos;
  bit flush_wait;
  int unsigned width_reg = HNG_WIDTH_RST;

  hng_in_t request_q[$];
  hng_out_t vertex_q[$];
  int fail_cnt = 0;
  bit no_gap_mode = 0;
  bit hold_go = 0;
  int gap_left = 0;
  int out_stall = 0;
  int idle_cycles = 0;

  function automatic int unsigned active_width();
    if (width_reg < 2) return 2;
    if (width_reg > HNG_MAX_WIDTH) return HNG_MAX_WIDTH;
    return width_reg;
  endfunction

  function automatic int unsigned line_rd(bit use_old, int unsigned i);
    if (i >= HNG_MAX_WIDTH) return 0;
    return use_old ? line_old[i] : line_new[i];
  endfunction

  // round(32768 * mag / sqrt(s)), ties away from zero
  function automatic int unsigned norm_scale(int unsigned mag, longint unsigned s);
    longint unsigned n, lim, t;
    int unsigned lo, hi, mid;
    n = longint'(mag) * 65536;
    lim = n * n;
    lo = 0;
    hi = 32768;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      t = 2 * longint'(mid) - 1;
      if (t * t * s <= lim) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic logic [15:0] norm_signed(int c, longint unsigned s);
    int unsigned q;
    q = norm_scale((c < 0) ? -c : c, s);
    return (c < 0) ? 16'(-q) : 16'(q);
  endfunction

  function automatic void push_vertex(int unsigned x, int unsigned z, int unsigned ctr,
                                      int l, int r, int d, int u, bit fin);
    hng_out_t v;
    int a, c;
    longint unsigned s;
    int unsigned ny;
    a = l - r;
    c = d - u;
    s = longint'(a * a + c * c) + 510 * 510;
    ny = norm_scale(510, s);
    if (ny > 32767) ny = 32767;
    v.grid_x = 10'(x);
    v.grid_z = 10'(z);
    v.height = 8'(ctr);
    v.normal_x = norm_signed(a, s);
    v.normal_y = 15'(ny);
    v.normal_z = norm_signed(c, s);
    v.last = fin;
    vertex_q = {vertex_q, v};
  endfunction

  function automatic void shift_line(int unsigned x, logic [7:0] v);
    if (x < HNG_MAX_WIDTH) begin
      line_old[x] = line_new[x];
      line_new[x] = v;
    end
  endfunction

  function automatic void predict_request(hng_in_t rq);
    int unsigned w, x, z, l, r, d;
    bit fin;
    w = active_width();
    if (rq.req_type == REQ_PIXEL) begin
      if (flush_wait) return;
      x = col_pos;
      z = row_pos;
      if (z >= 1) begin
        l = (x > 0) ? line_rd(1, x - 1) : 0;
        r = (x + 1 < w) ? line_rd(0, x + 1) : 0;
        d = (z >= 2) ? line_rd(1, x) : 0;
        push_vertex(x, z - 1, line_rd(0, x), l, r, d, rq.sample, 1'b0);
      end
      shift_line(x, rq.sample);
      col_pos = x + 1;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos = z + 1;
        if (row_pos >= w) begin
          flush_wait = 1;
          flush_pos = 0;
        end
      end
    end else begin
      if (!flush_wait) return;
      x = flush_pos;
      l = (x > 0) ? line_rd(1, x - 1) : 0;
      r = (x + 1 < w) ? line_rd(0, x + 1) : 0;
      fin = (x + 1 >= w);
      push_vertex(x, w - 1, line_rd(0, x), l, r, line_rd(1, x), 0, fin);
      shift_line(x, 8'd0);
      flush_pos = x + 1;
      if (fin) begin
        flush_wait = 0;
        flush_pos = 0;
        row_pos = 0;
        col_pos = 0;
      end
    end
  endfunction

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_request(in_data);
      if (in_valid && !in_ready) begin
        in_valid <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (request_q.size() > 0) begin
        in_data <= request_q.pop_front();
        in_valid <= 1'b1;
        gap_left <= no_gap_mode ? 0 : $urandom_range(0, 12);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    hng_out_t e;
    int st;
    st = out_stall;
    if (rst_n && out_valid && out_ready) begin
      if (vertex_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10) $display("unexpected vertex %p", out_data);
      end else begin
        e = vertex_q.pop_front();
        if (out_data !== e) begin
          fail_cnt++;
          if (fail_cnt <= 10) $display("vertex mismatch exp %p got %p", e, out_data);
        end
      end
      st = no_gap_mode ? 0 : $urandom_range(0, 12);
    end
    if (st > 0) st--;
    out_stall <= st;
    out_ready <= rst_n && !hold_go && st == 0;
  end

  // long receiver hold-off
  initial begin
    wait (hold_go);
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_go = 0;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("heightmap_normal_generator: mismatch");
      $finish;
    end
  end

  task automatic wait_idle();
    while (request_q.size() > 0 || in_valid || vertex_q.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_width(int unsigned val);
    wait_idle();
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= 2'd0;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    width_reg = val & 32'h7FF;
  endtask

  function automatic void add_pixel(int unsigned v);
    hng_in_t rq;
    rq.req_type = REQ_PIXEL;
    rq.sample = 8'(v);
    request_q = {request_q, rq};
  endfunction

  function automatic void add_flush();
    hng_in_t rq;
    rq.req_type = REQ_FLUSH;
    rq.sample = 8'($urandom);
    request_q = {request_q, rq};
  endfunction

  initial begin
    int unsigned w, sent;
    col_pos = 0;
    row_pos = 0;
    flush_pos = 0;
    flush_wait = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, ignored requests, flat interior
    write_width(3);
    add_flush();
    add_pixel(255); add_pixel(0); add_pixel(255);
    add_pixel(0); add_pixel(255); add_pixel(0);
    add_pixel(128); add_pixel(0); add_pixel(255);
    add_pixel(17);
    add_flush(); add_flush(); add_flush();
    repeat (9) add_pixel(77);
    add_flush(); add_flush(); add_flush();

    // clamped widths: one full-width row, then finish the frame at width 2
    write_width(2047);
    repeat (HNG_MAX_WIDTH) add_pixel($urandom_range(0, 255));
    write_width(0);
    add_pixel(255); add_pixel(1);
    add_flush(); add_flush();

    sent = 0;
    while (sent < 900) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 8);
      write_width(w);
      if (w < 2) w = 2;
      no_gap_mode = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < w * w; i++) begin
        if ($urandom_range(0, 19) == 0) add_flush();
        add_pixel($urandom_range(0, 255));
      end
      for (int i = 0; i < w; i++) begin
        if ($urandom_range(0, 9) == 0) add_pixel($urandom_range(0, 255));
        add_flush();
      end
      if (sent == 0) hold_go = 1;
      sent += w * w + w;
    end

    wait_idle();
    if (fail_cnt == 0 && vertex_q.size() == 0) begin
      $display("heightmap_normal_generator: match");
    end else begin
      $display("heightmap_normal_generator: mismatch");
    end
    $finish;
  end
endmodule

// ===== heightmap_normal_generator.f =====
rtl/hng_pkg.sv
rtl/hng_front.sv
rtl/hng_queue.sv
rtl/hng_back.sv
rtl/heightmap_normal_generator.sv
test/testbench.sv
